>>> rtl/wavhp_pkg.sv
// Shared types, constants and helpers for the WAV header parser.
// No dependencies.
package wavhp_pkg;

    localparam int unsigned HEADER_WINDOW = 8192;
    localparam int unsigned POS_W         = 14;

    localparam logic [31:0] SIG_RIFF = 32'h5249_4646;
    localparam logic [31:0] SIG_WAVE = 32'h5741_5645;
    localparam logic [31:0] SIG_FMT  = 32'h666D_7420;
    localparam logic [31:0] SIG_DATA = 32'h6461_7461;

    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] DEPTH_16  = 16'd16;
    localparam logic [15:0] DEPTH_24  = 16'd24;

    localparam logic [2:0] ST_PCM16     = 3'd0;
    localparam logic [2:0] ST_PCM24     = 3'd1;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd2;
    localparam logic [2:0] ST_BROKEN    = 3'd3;
    localparam logic [2:0] ST_NOT_PCM   = 3'd4;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd5;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       first_byte;
        logic       stream_end;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] bits_per_sample;
        logic [13:0] data_start;
        logic [32:0] data_stop;
    } result_t;

    function automatic logic [7:0] sig_byte(input logic [31:0] sig, input logic [1:0] idx);
        logic [7:0] res;
        case (idx)
            2'd0:    res = sig[31:24];
            2'd1:    res = sig[23:16];
            2'd2:    res = sig[15:8];
            default: res = sig[7:0];
        endcase
        return res;
    endfunction

endpackage

>>> rtl/wavhp_in_reg.sv
// Input holding register for header bytes.
// Depends on wavhp_pkg.
module wavhp_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  wavhp_pkg::item_t s_item,
    output logic            item_valid,
    output wavhp_pkg::item_t item,
    input  logic            take
);
    import wavhp_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    assign s_ready    = !vld_reg || take;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb begin
        vld_next = vld_reg;
        if (s_valid && s_ready) begin
            vld_next = 1'b1;
        end else if (take) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

>>> rtl/wavhp_parse.sv
// Parser state and per-byte decision logic (RIFF/WAVE, chunk walk, fmt capture).
// Depends on wavhp_pkg.
module wavhp_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  wavhp_pkg::item_t  item,
    input  logic              advance,
    output logic              res_valid,
    output wavhp_pkg::result_t res
);
    import wavhp_pkg::*;

    localparam logic [2:0] PH_RIFF      = 3'd0;
    localparam logic [2:0] PH_SEEK_FMT  = 3'd1;
    localparam logic [2:0] PH_SEEK_DATA = 3'd2;
    localparam logic [2:0] PH_DATA_SIZE = 3'd3;
    localparam logic [2:0] PH_DATA_DONE = 3'd4;
    localparam logic [2:0] PH_WALK_FAIL = 3'd5;

    localparam logic [POS_W-1:0] WIN       = POS_W'(HEADER_WINDOW);
    localparam logic [POS_W-1:0] FMT_LIMIT = POS_W'(HEADER_WINDOW - 24);
    localparam logic [32:0]      NXT_LIMIT = 33'(HEADER_WINDOW - 8);

    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [POS_W-1:0] nco_reg,      nco_next;
    logic [2:0]       phase_reg,    phase_next;
    logic [31:0]      id_reg,       id_next;
    logic [31:0]      size_reg,     size_next;
    logic [63:0]      fmt_reg,      fmt_next;
    logic [15:0]      depth_reg,    depth_next;
    logic             fin_reg,      fin_next;
    logic [POS_W-1:0] fbase_reg,    fbase_next;
    logic             fseen_reg,    fseen_next;
    logic [13:0]      dstart_reg,   dstart_next;
    logic [32:0]      dstop_reg,    dstop_next;

    logic [POS_W-1:0] cur;
    logic [POS_W-1:0] diff;
    logic [POS_W-1:0] r;
    logic [32:0]      nxt;
    logic [7:0]       b;
    logic             emit;
    logic [2:0]       status;
    logic             full;

    assign b = item.header_byte;

    always_comb begin
        pos_next    = pos_reg;
        nco_next    = nco_reg;
        phase_next  = phase_reg;
        id_next     = id_reg;
        size_next   = size_reg;
        fmt_next    = fmt_reg;
        depth_next  = depth_reg;
        fin_next    = fin_reg;
        fbase_next  = fbase_reg;
        fseen_next  = fseen_reg;
        dstart_next = dstart_reg;
        dstop_next  = dstop_reg;
        emit   = 1'b0;
        status = ST_BROKEN;
        cur    = '0;
        diff   = '0;
        r      = '0;
        nxt    = '0;

        if (item.first_byte) begin
            pos_next    = '0;
            nco_next    = POS_W'(12);
            phase_next  = PH_RIFF;
            id_next     = '0;
            size_next   = '0;
            fmt_next    = '0;
            depth_next  = '0;
            fin_next    = 1'b0;
            fbase_next  = '0;
            fseen_next  = 1'b0;
            dstart_next = '0;
            dstop_next  = '0;
        end

        if (!fin_next) begin
            cur = pos_next;
            if (pos_next < WIN) begin
                pos_next = pos_next + POS_W'(1);
            end
            diff = cur - nco_next;

            if (phase_next == PH_RIFF) begin
                if (cur < POS_W'(4)) begin
                    if (b != sig_byte(SIG_RIFF, cur[1:0])) begin
                        emit   = 1'b1;
                        status = ST_NOT_RIFF;
                    end
                end else if (cur >= POS_W'(8) && cur < POS_W'(12)) begin
                    if (b != sig_byte(SIG_WAVE, cur[1:0])) begin
                        emit   = 1'b1;
                        status = ST_NOT_RIFF;
                    end else if (cur == POS_W'(11)) begin
                        phase_next = PH_SEEK_FMT;
                    end
                end
            end else if (phase_next <= PH_DATA_SIZE && cur >= nco_next
                         && diff < POS_W'(8)) begin
                if (!diff[2]) begin
                    id_next = {id_next[23:0], b};
                    if (diff[1:0] == 2'd3) begin
                        if (phase_next == PH_SEEK_FMT && id_next == SIG_FMT) begin
                            if (nco_next > FMT_LIMIT) begin
                                emit   = 1'b1;
                                status = ST_BROKEN;
                            end else begin
                                fbase_next = nco_next;
                                fseen_next = 1'b1;
                                phase_next = PH_SEEK_DATA;
                            end
                        end else if (phase_next == PH_SEEK_DATA && id_next == SIG_DATA) begin
                            dstart_next = nco_next + 14'd8;
                            phase_next  = PH_DATA_SIZE;
                        end
                    end
                end else begin
                    size_next = {b, size_next[31:8]};
                    if (diff[1:0] == 2'd3) begin
                        if (phase_next == PH_DATA_SIZE) begin
                            dstop_next = {19'd0, dstart_next} + {1'b0, size_next};
                            phase_next = PH_DATA_DONE;
                        end else begin
                            nxt = {19'd0, nco_next} + {1'b0, size_next} + 33'd8;
                            if (nxt > NXT_LIMIT) begin
                                if (phase_next == PH_SEEK_FMT) begin
                                    emit   = 1'b1;
                                    status = ST_BROKEN;
                                end else begin
                                    phase_next = PH_WALK_FAIL;
                                end
                            end else begin
                                nco_next = nxt[POS_W-1:0];
                            end
                        end
                    end
                end
            end

            if (!emit && fseen_next && cur >= fbase_next) begin
                r = cur - fbase_next;
                if (r >= POS_W'(8) && r < POS_W'(16)) begin
                    fmt_next[{r[2:0], 3'b000} +: 8] = fmt_next[{r[2:0], 3'b000} +: 8] | b;
                end else if (r == POS_W'(22) || r == POS_W'(23)) begin
                    depth_next[{r[0], 3'b000} +: 8] = depth_next[{r[0], 3'b000} +: 8] | b;
                end
                if (r >= POS_W'(9)) begin
                    if (fmt_next[15:0] != FMT_PCM) begin
                        emit   = 1'b1;
                        status = ST_NOT_PCM;
                    end else if (phase_next == PH_WALK_FAIL) begin
                        emit   = 1'b1;
                        status = ST_BROKEN;
                    end else if (phase_next == PH_DATA_DONE && r >= POS_W'(23)) begin
                        emit = 1'b1;
                        if (depth_next == DEPTH_16) begin
                            status = ST_PCM16;
                        end else if (depth_next == DEPTH_24) begin
                            status = ST_PCM24;
                        end else begin
                            status = ST_BAD_DEPTH;
                        end
                    end
                end
            end

            if (!emit && item.stream_end) begin
                emit   = 1'b1;
                status = ST_BROKEN;
            end

            if (emit) begin
                fin_next = 1'b1;
            end
        end
    end

    assign full = (status == ST_PCM16) || (status == ST_PCM24) || (status == ST_BAD_DEPTH);

    assign res_valid           = emit;
    assign res.status          = status;
    assign res.channel_count   = full ? fmt_next[31:16] : 16'd0;
    assign res.rate_hz         = full ? fmt_next[63:32] : 32'd0;
    assign res.bits_per_sample = full ? depth_next      : 16'd0;
    assign res.data_start      = full ? dstart_next     : 14'd0;
    assign res.data_stop       = full ? dstop_next      : 33'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            nco_reg    <= POS_W'(12);
            phase_reg  <= PH_RIFF;
            id_reg     <= '0;
            size_reg   <= '0;
            fmt_reg    <= '0;
            depth_reg  <= '0;
            fin_reg    <= 1'b0;
            fbase_reg  <= '0;
            fseen_reg  <= 1'b0;
            dstart_reg <= '0;
            dstop_reg  <= '0;
        end else if (advance) begin
            pos_reg    <= pos_next;
            nco_reg    <= nco_next;
            phase_reg  <= phase_next;
            id_reg     <= id_next;
            size_reg   <= size_next;
            fmt_reg    <= fmt_next;
            depth_reg  <= depth_next;
            fin_reg    <= fin_next;
            fbase_reg  <= fbase_next;
            fseen_reg  <= fseen_next;
            dstart_reg <= dstart_next;
            dstop_reg  <= dstop_next;
        end
    end

endmodule

>>> rtl/wavhp_out_reg.sv
// Result register with valid/ready handshake.
// Depends on wavhp_pkg.
module wavhp_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  wavhp_pkg::result_t res,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output wavhp_pkg::result_t m_res
);
    import wavhp_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign free    = !vld_reg || m_ready;
    assign m_valid = vld_reg;
    assign m_res   = res_reg;

    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

>>> rtl/wav_header_parser_core.sv
// WAV header parser top level: input register, parse logic, result register.
// Depends on wavhp_pkg, wavhp_in_reg, wavhp_parse, wavhp_out_reg.
//
//   channel  | direction | ports
//   ---------+-----------+------------------------------------------------
//   s_       | in        | s_valid s_ready s_header_byte s_first_byte s_stream_end
//   m_       | out       | m_valid m_ready m_status ... m_data_stop
//
// One byte per cycle sustained; a byte's result is valid on m_ once the byte has passed
// the input register and the decision has loaded the result register.
// Reset (aresetn low, synchronous) empties both registers and returns the parser
// to offset 0; a byte with first_byte set restarts it as well.
// A held result with m_ready low stalls the parser; s_ready then drops once the
// input register holds a byte.
module wav_header_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_header_byte,
    input  logic        s_first_byte,
    input  logic        s_stream_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_channel_count,
    output logic [31:0] m_rate_hz,
    output logic [15:0] m_bits_per_sample,
    output logic [13:0] m_data_start,
    output logic [32:0] m_data_stop
);
    import wavhp_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    out_free;
    logic    res_valid;
    result_t res;
    result_t m_res;

    assign s_item.header_byte = s_header_byte;
    assign s_item.first_byte  = s_first_byte;
    assign s_item.stream_end  = s_stream_end;

    assign advance = item_valid && out_free;

    wavhp_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (advance)
    );

    wavhp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    wavhp_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && res_valid),
        .res     (res),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_status          = m_res.status;
    assign m_channel_count   = m_res.channel_count;
    assign m_rate_hz         = m_res.rate_hz;
    assign m_bits_per_sample = m_res.bits_per_sample;
    assign m_data_start      = m_res.data_start;
    assign m_data_stop       = m_res.data_stop;

endmodule

>>> rtl/wavhp_checker.sv
// Port-level checks for wav_header_parser_core, attached by bind.
// Depends on wavhp_pkg.
module wavhp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [15:0] m_channel_count,
    input logic [31:0] m_rate_hz,
    input logic [15:0] m_bits_per_sample,
    input logic [13:0] m_data_start,
    input logic [32:0] m_data_stop
);
    import wavhp_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_data_stop))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_BAD_DEPTH)
        else $error("status code out of range");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_NOT_RIFF || m_status == ST_BROKEN
                    || m_status == ST_NOT_PCM)
        |-> m_channel_count == 16'd0 && m_rate_hz == 32'd0
            && m_bits_per_sample == 16'd0 && m_data_start == 14'd0
            && m_data_stop == 33'd0)
        else $error("error result carries field values");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_PCM16 || m_status == ST_PCM24)
        |-> m_bits_per_sample == ((m_status == ST_PCM16) ? DEPTH_16 : DEPTH_24))
        else $error("depth does not match status");

    a_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_PCM16 || m_status == ST_PCM24)
        |-> m_data_stop >= {19'd0, m_data_start} && m_data_start >= 14'd20)
        else $error("data span inconsistent");

endmodule

bind wav_header_parser_core wavhp_checker u_wavhp_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_channel_count   (m_channel_count),
    .m_rate_hz         (m_rate_hz),
    .m_bits_per_sample (m_bits_per_sample),
    .m_data_start      (m_data_start),
    .m_data_stop       (m_data_stop)
);

>>> tb/sv/wav_header_parser_core_tb.sv
// Testbench for wav_header_parser_core: streams WAV headers a byte per transfer,
// predicts the parse verdict of every accepted byte and checks each result transfer.
// Depends on wavhp_pkg and the wav_header_parser_core RTL.
module wav_header_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wavhp_pkg::*;

    typedef enum logic [2:0] {
        AWAIT_RIFF,
        SEEK_FMT,
        SEEK_DATA,
        READ_DATA_SIZE,
        DATA_DONE,
        WALK_FAILED
    } parse_phase_t;

    typedef struct {
        bit          with_first;
        int          n_pre;
        longint      pre_size;     // negative: random small
        logic [31:0] pre_id;       // zero: random id
        logic [15:0] fmt_code;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] depth;
        int          fmt_size;
        int          n_mid;
        longint      mid_size;
        logic [31:0] mid_id;
        logic [31:0] data_size;
        int          corrupt_at;   // negative: none
        logic [7:0]  corrupt_mask;
        int          keep;         // negative: whole header
        bit          end_flag;
        int          trailing;
        longint      body_cap;     // chunks larger than this end the header
    } wav_plan_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_header_byte = '0;
    logic        s_first_byte = 1'b0;
    logic        s_stream_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_channel_count;
    logic [31:0] m_rate_hz;
    logic [15:0] m_bits_per_sample;
    logic [13:0] m_data_start;
    logic [32:0] m_data_stop;

    wav_header_parser_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_header_byte     (s_header_byte),
        .s_first_byte      (s_first_byte),
        .s_stream_end      (s_stream_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_channel_count   (m_channel_count),
        .m_rate_hz         (m_rate_hz),
        .m_bits_per_sample (m_bits_per_sample),
        .m_data_start      (m_data_start),
        .m_data_stop       (m_data_stop)
    );

    always #4 aclk = ~aclk;

    item_t      byte_feed[$];
    result_t    expected_verdicts[$];
    logic [7:0] hdr_bytes[$];
    int         error_count = 0;

    // parser shadow state
    longint unsigned pos_count;
    longint unsigned chunk_at;
    parse_phase_t    phase;
    logic [31:0]     id_window;
    logic [31:0]     size_window;
    logic [63:0]     fmt_bits;
    logic [15:0]     depth_bits;
    bit              verdict_given;
    longint unsigned fmt_at;
    bit              fmt_found;
    longint unsigned data_begin;
    longint unsigned data_end;

    function automatic void clear_parser();
        pos_count = 0;
        chunk_at = 12;
        phase = AWAIT_RIFF;
        id_window = '0;
        size_window = '0;
        fmt_bits = '0;
        depth_bits = '0;
        verdict_given = 1'b0;
        fmt_at = 0;
        fmt_found = 1'b0;
        data_begin = 0;
        data_end = 0;
    endfunction

    function automatic result_t close_parse(input logic [2:0] code);
        result_t r;
        r = '0;
        r.status = code;
        if (code == ST_PCM16 || code == ST_PCM24 || code == ST_BAD_DEPTH) begin
            r.channel_count = fmt_bits[31:16];
            r.rate_hz = fmt_bits[63:32];
            r.bits_per_sample = depth_bits;
            r.data_start = data_begin[13:0];
            r.data_stop = data_end[32:0];
        end
        verdict_given = 1'b1;
        return r;
    endfunction

    function automatic bit predict_parse(input item_t it, output result_t res);
        longint unsigned cur;
        longint unsigned rel;
        longint unsigned r;
        longint unsigned nxt;
        logic [7:0]      b;
        b = it.header_byte;
        res = '0;
        if (it.first_byte) clear_parser();
        if (verdict_given) return 1'b0;
        cur = pos_count;
        if (pos_count < HEADER_WINDOW) pos_count++;

        if (phase == AWAIT_RIFF) begin
            if (cur < 4) begin
                if (b != SIG_RIFF[8*(3-cur) +: 8]) begin
                    res = close_parse(ST_NOT_RIFF);
                    return 1'b1;
                end
            end else if (cur >= 8 && cur < 12) begin
                if (b != SIG_WAVE[8*(11-cur) +: 8]) begin
                    res = close_parse(ST_NOT_RIFF);
                    return 1'b1;
                end
                if (cur == 11) phase = SEEK_FMT;
            end
        end else if (phase <= READ_DATA_SIZE && cur >= chunk_at && cur - chunk_at < 8) begin
            rel = cur - chunk_at;
            if (rel < 4) begin
                id_window = {id_window[23:0], b};
                if (rel == 3) begin
                    if (phase == SEEK_FMT && id_window == SIG_FMT) begin
                        if (chunk_at > HEADER_WINDOW - 24) begin
                            res = close_parse(ST_BROKEN);
                            return 1'b1;
                        end
                        fmt_at = chunk_at;
                        fmt_found = 1'b1;
                        phase = SEEK_DATA;
                    end else if (phase == SEEK_DATA && id_window == SIG_DATA) begin
                        data_begin = chunk_at + 8;
                        phase = READ_DATA_SIZE;
                    end
                end
            end else begin
                size_window = {b, size_window[31:8]};
                if (rel == 7) begin
                    if (phase == READ_DATA_SIZE) begin
                        data_end = data_begin + 64'(size_window);
                        phase = DATA_DONE;
                    end else begin
                        // no 32-bit wrap on the next chunk offset
                        nxt = chunk_at + 64'(size_window) + 8;
                        if (nxt > HEADER_WINDOW - 8) begin
                            if (phase == SEEK_FMT) begin
                                res = close_parse(ST_BROKEN);
                                return 1'b1;
                            end
                            phase = WALK_FAILED;
                        end else begin
                            chunk_at = nxt;
                        end
                    end
                end
            end
        end

        // fmt fields are taken by offset, even if a later chunk overlaps them
        if (fmt_found && cur >= fmt_at) begin
            r = cur - fmt_at;
            if (r >= 8 && r < 16)
                fmt_bits = fmt_bits | (64'(b) << (8 * (r - 8)));
            else if (r == 22 || r == 23)
                depth_bits = depth_bits | (16'(b) << (8 * (r - 22)));
            if (r >= 9) begin
                if (fmt_bits[15:0] != FMT_PCM) begin
                    res = close_parse(ST_NOT_PCM);
                    return 1'b1;
                end
                if (phase == WALK_FAILED) begin
                    res = close_parse(ST_BROKEN);
                    return 1'b1;
                end
                if (phase == DATA_DONE && r >= 23) begin
                    if (depth_bits == DEPTH_16) res = close_parse(ST_PCM16);
                    else if (depth_bits == DEPTH_24) res = close_parse(ST_PCM24);
                    else res = close_parse(ST_BAD_DEPTH);
                    return 1'b1;
                end
            end
        end

        if (it.stream_end) begin
            res = close_parse(ST_BROKEN);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // header construction
    task automatic push_id(input logic [31:0] id);
        for (int k = 3; k >= 0; k--) hdr_bytes.push_back(id[8*k +: 8]);
    endtask

    task automatic push_le(input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++) hdr_bytes.push_back(v[8*k +: 8]);
    endtask

    task automatic push_fill(input int n);
        repeat (n) hdr_bytes.push_back(8'($urandom));
    endtask

    function automatic logic [31:0] random_id();
        logic [31:0] id;
        do id = $urandom; while (id == SIG_FMT || id == SIG_DATA);
        return id;
    endfunction

    task automatic push_chunks(input int count, input longint size, input logic [31:0] id,
                               input longint cap, inout bit stopped);
        longint sz;
        for (int i = 0; i < count && !stopped; i++) begin
            sz = (size < 0) ? longint'($urandom_range(0, 24)) : size;
            push_id(id != '0 ? id : random_id());
            push_le(sz[31:0], 4);
            if (sz > cap) stopped = 1'b1;
            else push_fill(int'(sz));
        end
    endtask

    task automatic add_wav(input wav_plan_t p);
        bit stopped;
        int kept;
        stopped = 1'b0;
        hdr_bytes.delete();
        push_id(SIG_RIFF);
        push_le($urandom, 4);
        push_id(SIG_WAVE);
        push_chunks(p.n_pre, p.pre_size, p.pre_id, p.body_cap, stopped);
        if (!stopped) begin
            push_id(SIG_FMT);
            push_le(p.fmt_size, 4);
            push_le(32'(p.fmt_code), 2);
            push_le(32'(p.channels), 2);
            push_le(p.rate, 4);
            push_le($urandom, 4);
            push_le($urandom, 2);
            push_le(32'(p.depth), 2);
            if (p.fmt_size < 16) repeat (16 - p.fmt_size) void'(hdr_bytes.pop_back());
            else push_fill(p.fmt_size - 16);
            push_chunks(p.n_mid, p.mid_size, p.mid_id, p.body_cap, stopped);
        end
        if (!stopped) begin
            push_id(SIG_DATA);
            push_le(p.data_size, 4);
        end
        push_fill(p.trailing);
        if (p.corrupt_at >= 0 && p.corrupt_at < hdr_bytes.size())
            hdr_bytes[p.corrupt_at] ^= p.corrupt_mask;
        kept = (p.keep >= 0 && p.keep < hdr_bytes.size()) ? p.keep : hdr_bytes.size();
        for (int i = 0; i < kept; i++)
            byte_feed.push_back(item_t'{hdr_bytes[i], p.with_first && i == 0,
                                        p.end_flag && i == kept - 1});
    endtask

    function automatic wav_plan_t base_plan();
        wav_plan_t p;
        p.with_first = 1'b1;
        p.n_pre = $urandom_range(0, 2);
        p.pre_size = -1;
        p.pre_id = '0;
        p.fmt_code = FMT_PCM;
        p.channels = 16'($urandom_range(1, 8));
        p.rate = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: p.depth = DEPTH_16;
            4, 5, 6, 7: p.depth = DEPTH_24;
            8:          p.depth = 16'($urandom);
            default:    p.depth = DEPTH_16 ^ (16'd1 << $urandom_range(0, 15));
        endcase
        p.fmt_size = 16;
        p.n_mid = $urandom_range(0, 2);
        p.mid_size = -1;
        p.mid_id = '0;
        p.data_size = $urandom;
        p.corrupt_at = -1;
        p.corrupt_mask = '0;
        p.keep = -1;
        p.end_flag = 1'b1;
        p.trailing = $urandom_range(0, 6);
        p.body_cap = 64;
        return p;
    endfunction

    // driver
    result_t predicted;
    item_t   feed_item;
    int      burst_left = 0;
    int      gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            clear_parser();
        end else begin
            if (s_valid && s_ready) begin
                if (predict_parse(item_t'{s_header_byte, s_first_byte, s_stream_end},
                                  predicted))
                    expected_verdicts.push_back(predicted);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || byte_feed.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    feed_item = byte_feed.pop_front();
                    s_valid <= 1'b1;
                    s_header_byte <= feed_item.header_byte;
                    s_first_byte <= feed_item.first_byte;
                    s_stream_end <= feed_item.stream_end;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // monitor
    result_t     oldest;
    int          hold_left = 0;
    logic [15:0] ready_cycle = '0;

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result transfer with nothing expected, status %0d", m_status);
                    error_count++;
                end else begin
                    oldest = expected_verdicts.pop_front();
                    check_field("status", oldest.status, m_status);
                    check_field("channel_count", oldest.channel_count, m_channel_count);
                    check_field("rate_hz", oldest.rate_hz, m_rate_hz);
                    check_field("bits_per_sample", oldest.bits_per_sample,
                                m_bits_per_sample);
                    check_field("data_start", oldest.data_start, m_data_start);
                    check_field("data_stop", oldest.data_stop, m_data_stop);
                end
            end
            ready_cycle <= ready_cycle + 16'd1;
            if (ready_cycle[10]) begin
                m_ready <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 10);
            end
        end
    end

    // stimulus and end of run
    initial begin
        wav_plan_t p;
        int        pick;

        // no first_byte flag right after reset
        p = base_plan(); p.with_first = 1'b0; p.depth = DEPTH_16; add_wav(p);
        p = base_plan(); p.depth = DEPTH_24; add_wav(p);
        // header after a verdict without first_byte is ignored
        p = base_plan(); p.with_first = 1'b0; add_wav(p);
        p = base_plan(); p.depth = 16'd8; add_wav(p);
        p = base_plan(); p.channels = '1; p.rate = '1; p.depth = '1; add_wav(p);
        p = base_plan(); p.channels = '0; p.rate = '0; p.data_size = '0;
        p.depth = DEPTH_16; p.n_pre = 0; p.n_mid = 0; add_wav(p);
        // bad signatures at both ends of RIFF and WAVE
        p = base_plan(); p.corrupt_at = 0; p.corrupt_mask = 8'h80; add_wav(p);
        p = base_plan(); p.corrupt_at = 3; p.corrupt_mask = 8'h01; add_wav(p);
        p = base_plan(); p.corrupt_at = 8; p.corrupt_mask = 8'hFF; add_wav(p);
        p = base_plan(); p.corrupt_at = 11; p.corrupt_mask = 8'h20; add_wav(p);
        // not PCM, low and high byte of the format code
        p = base_plan(); p.fmt_code = 16'd3; add_wav(p);
        p = base_plan(); p.fmt_code = 16'h0101; add_wav(p);
        // chunk walk leaving the window, before and after fmt
        p = base_plan(); p.n_pre = 1; p.pre_size = 32'hFFFF_FFFF; add_wav(p);
        p = base_plan(); p.n_pre = 1; p.pre_size = 8165; add_wav(p);
        p = base_plan(); p.n_pre = 0; p.n_mid = 1; p.mid_size = 8141; add_wav(p);
        // stream end on the deciding byte, and one byte short of it
        p = base_plan(); p.n_pre = 0; p.n_mid = 0; p.depth = DEPTH_24; p.keep = 44;
        add_wav(p);
        p = base_plan(); p.n_pre = 0; p.n_mid = 0; p.keep = 43; add_wav(p);
        p = base_plan(); p.keep = 5; add_wav(p);
        // one-byte streams
        p = base_plan(); p.keep = 1; add_wav(p);
        p = base_plan(); p.keep = 1; p.corrupt_at = 0; p.corrupt_mask = 8'h04; add_wav(p);
        // restart in the middle of a parse
        p = base_plan(); p.keep = 30; p.end_flag = 1'b0; add_wav(p);
        // fmt shorter than its fields: the next chunk overlaps them
        p = base_plan(); p.fmt_size = 8; p.n_mid = 1; add_wav(p);
        p = base_plan(); p.fmt_size = 18; p.pre_id = SIG_DATA; p.n_pre = 1;
        p.mid_id = SIG_FMT; p.n_mid = 1; add_wav(p);
        p = base_plan(); p.n_pre = 3; p.pre_size = 0; p.trailing = 5; add_wav(p);

        while (byte_feed.size() < 1900) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 20))
                    byte_feed.push_back(item_t'{8'($urandom), $urandom_range(0, 3) == 0,
                                                $urandom_range(0, 7) == 0});
            end else begin
                p = base_plan();
                if ($urandom_range(0, 9) == 0) p.fmt_code = 16'($urandom);
                case ($urandom_range(0, 19))
                    0, 1, 2: p.fmt_size = $urandom_range(17, 40);
                    3, 4:    p.fmt_size = $urandom_range(0, 15);
                    default: ;
                endcase
                if ($urandom_range(0, 2) == 0) p.channels = 16'($urandom);
                if ($urandom_range(0, 9) == 0) p.pre_id = SIG_DATA;
                if ($urandom_range(0, 9) == 0) p.mid_id = SIG_FMT;
                if (pick >= 55 && pick < 70) begin
                    p.corrupt_at = $urandom_range(0, 60);
                    p.corrupt_mask = 8'($urandom_range(1, 255));
                end else if (pick >= 70 && pick < 80) begin
                    p.keep = $urandom_range(1, 60);
                end else if (pick >= 80 && pick < 88) begin
                    p.keep = $urandom_range(1, 60);
                    p.end_flag = 1'b0;
                end else if (pick >= 88 && pick < 96) begin
                    if ($urandom_range(0, 1) == 0) begin
                        p.n_pre = 1;
                        p.pre_size = ($urandom_range(0, 1) == 0) ?
                                     longint'($urandom | 32'h8000_0000) :
                                     longint'($urandom_range(8141, 8300));
                    end else begin
                        p.n_mid = 1;
                        p.mid_size = ($urandom_range(0, 1) == 0) ?
                                     longint'($urandom | 32'h8000_0000) :
                                     longint'($urandom_range(8141, 8300));
                    end
                end else if (pick >= 96) begin
                    p.with_first = 1'b0;
                end
                add_wav(p);
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_feed.size() != 0 || s_valid) @(posedge aclk);
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (error_count == 0 && expected_verdicts.size() == 0) begin
            $display("PASS wav_header_parser_core");
        end else begin
            $display("FAIL wav_header_parser_core");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL wav_header_parser_core");
        $finish;
    end

endmodule
